>>> sv/bcsh_pkg.sv
// ----------------------------------------------------------------------------
// bcsh_pkg
// Shared types and constants of the stereo bit crusher with sample and hold.
// ----------------------------------------------------------------------------
package bcsh_pkg;

	// default geometry, handed to the top level as parameter defaults
	localparam int DEF_SAMPLE_WIDTH    = 24;
	localparam int DEF_PHASE_FRAC_BITS = 16;

	// bit depth register, depths at or above PASS_DEPTH leave samples untouched
	localparam int                   BIT_DEPTH_W  = 5;
	localparam logic [BIT_DEPTH_W-1:0] PASS_DEPTH = 5'd16;

	// configuration register map
	localparam int CFG_ADDR_W = 1;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_BIT_DEPTH = 1'b0,
		REG_PHASE_INC = 1'b1
	} cfg_reg_t;

endpackage

>>> sv/bcsh_phase.sv
// ----------------------------------------------------------------------------
// bcsh_phase
// Phase accumulator that flags the items on which the hold registers capture.
// ----------------------------------------------------------------------------
module bcsh_phase import bcsh_pkg::*; #(
	parameter int PHASE_FRAC_BITS = DEF_PHASE_FRAC_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [PHASE_FRAC_BITS:0] phase_inc,
	output logic                     capture
);

	localparam logic [PHASE_FRAC_BITS:0] PHASE_ONE = (PHASE_FRAC_BITS + 1)'(1) << PHASE_FRAC_BITS;

	// phase stays below 1.0 between items, so the integer bit is never stored
	logic [PHASE_FRAC_BITS-1:0] phase_acc_q;
	logic [PHASE_FRAC_BITS:0]   inc_sat;
	logic [PHASE_FRAC_BITS:0]   sum;

	always_comb begin
		inc_sat = (phase_inc > PHASE_ONE) ? PHASE_ONE : phase_inc;
		sum     = {1'b0, phase_acc_q} + inc_sat;
		capture = sum[PHASE_FRAC_BITS];
	end

	// dropping by 1.0 is clearing the integer bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
		end else if (step) begin
			phase_acc_q <= sum[PHASE_FRAC_BITS-1:0];
		end
	end

endmodule

>>> sv/bcsh_quant.sv
// ----------------------------------------------------------------------------
// bcsh_quant
// Rounds one sample half away from zero to the step set by the bit depth.
// ----------------------------------------------------------------------------
module bcsh_quant import bcsh_pkg::*; #(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input  logic [BIT_DEPTH_W-1:0]         bit_depth,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic signed [SAMPLE_WIDTH-1:0] result
);

	localparam int KW = $clog2(SAMPLE_WIDTH);
	localparam logic [SAMPLE_WIDTH:0] SIGN_ONE = (SAMPLE_WIDTH + 1)'(1) << (SAMPLE_WIDTH - 1);
	localparam logic [SAMPLE_WIDTH-1:0] MAX_POS = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};

	logic                    neg;
	logic [SAMPLE_WIDTH-1:0] mag;
	logic [KW-1:0]           k;
	logic [SAMPLE_WIDTH:0]   half;
	logic [SAMPLE_WIDTH:0]   rounded;

	always_comb begin
		neg     = sample[SAMPLE_WIDTH-1];
		mag     = neg ? SAMPLE_WIDTH'(~sample + 1'b1) : SAMPLE_WIDTH'(sample);
		// step is 2^k lsbs; only depths below PASS_DEPTH reach the rounding path
		k       = KW'(SAMPLE_WIDTH - 1) - KW'(bit_depth[3:0]);
		// half a step, zero when the step is one lsb
		half    = ((SAMPLE_WIDTH + 1)'(1) << k) >> 1;
		rounded = ({1'b0, mag} + half) & ({(SAMPLE_WIDTH + 1){1'b1}} << k);
		if (bit_depth >= PASS_DEPTH) begin
			result = sample;
		end else if (!neg) begin
			// +1.0 saturates to the largest positive code
			result = (rounded >= SIGN_ONE) ? MAX_POS : rounded[SAMPLE_WIDTH-1:0];
		end else begin
			// a negative magnitude never rounds past 2^(w-1)
			result = SAMPLE_WIDTH'(~rounded[SAMPLE_WIDTH-1:0] + 1'b1);
		end
	end

endmodule

>>> sv/bitcrusher_sample_hold.sv
// ----------------------------------------------------------------------------
// bitcrusher_sample_hold
// Stereo bit crusher: phase-driven sample and hold with bit depth rounding.
// ----------------------------------------------------------------------------
//
//  channel  signals                         item
//  -------  ------------------------------  ----------------------------------
//  in       in_valid / in_ready             left_in, right_in (signed Q1.23)
//  out      out_valid / out_ready           left_out, right_out (signed Q1.23)
//  cfg      cfg_we, cfg_addr, cfg_wdata     0: bit_depth, 1: phase_increment
//
//  one item per cycle sustained while out is ready; each item passes
//  through the input stage and then the output register
//  the phase accumulator steps when an item is taken, the rounding runs
//  between the input stage and the hold registers
//  the output register doubles as the hold registers, so a stall on out
//  freezes the held samples; in stays ready while the input stage can move
//  arst_n clears the pipeline, phase and held samples and restores the
//  configuration to full depth and increment 1.0
//
module bitcrusher_sample_hold import bcsh_pkg::*; #(
	parameter int SAMPLE_WIDTH    = DEF_SAMPLE_WIDTH,
	parameter int PHASE_FRAC_BITS = DEF_PHASE_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input items
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] left_in,
	input  logic signed [SAMPLE_WIDTH-1:0] right_in,
	// result items
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] left_out,
	output logic signed [SAMPLE_WIDTH-1:0] right_out,
	// configuration writes
	input  logic                           cfg_we,
	input  logic [CFG_ADDR_W-1:0]          cfg_addr,
	input  logic [PHASE_FRAC_BITS:0]       cfg_wdata
);

	localparam logic [PHASE_FRAC_BITS:0] PHASE_ONE = (PHASE_FRAC_BITS + 1)'(1) << PHASE_FRAC_BITS;

	// configuration registers
	logic [BIT_DEPTH_W-1:0]   bit_depth_q;
	logic [PHASE_FRAC_BITS:0] phase_inc_q;

	// input stage
	logic                           valid_s1;
	logic                           capture_s1;
	logic signed [SAMPLE_WIDTH-1:0] left_s1;
	logic signed [SAMPLE_WIDTH-1:0] right_s1;

	// output register, also the hold registers
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] held_left_q;
	logic signed [SAMPLE_WIDTH-1:0] held_right_q;

	logic                           in_take;
	logic                           advance;
	logic                           capture;
	logic signed [SAMPLE_WIDTH-1:0] left_crushed;
	logic signed [SAMPLE_WIDTH-1:0] right_crushed;

	// register writes, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_depth_q <= PASS_DEPTH;
			phase_inc_q <= PHASE_ONE;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_BIT_DEPTH: bit_depth_q <= cfg_wdata[BIT_DEPTH_W-1:0];
				REG_PHASE_INC: phase_inc_q <= cfg_wdata;
				default:       ;
			endcase
		end
	end

	// handshake: the input stage moves when the output register is free or drains
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || !out_valid_q || out_ready;
	assign in_take  = in_valid && in_ready;

	// phase decides on accept whether this item is captured
	bcsh_phase #(
		.PHASE_FRAC_BITS(PHASE_FRAC_BITS)
	) u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (in_take),
		.phase_inc(phase_inc_q),
		.capture  (capture)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// samples and capture flag need no reset, qualified by valid_s1
	always_ff @(posedge clk) begin
		if (in_take) begin
			left_s1    <= left_in;
			right_s1   <= right_in;
			capture_s1 <= capture;
		end
	end

	// one rounding unit per channel
	bcsh_quant #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_quant_left (
		.bit_depth(bit_depth_q),
		.sample   (left_s1),
		.result   (left_crushed)
	);

	bcsh_quant #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_quant_right (
		.bit_depth(bit_depth_q),
		.sample   (right_s1),
		.result   (right_crushed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// held samples are state, so they reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_left_q  <= '0;
			held_right_q <= '0;
		end else if (advance && capture_s1) begin
			held_left_q  <= left_crushed;
			held_right_q <= right_crushed;
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = held_left_q;
	assign right_out = held_right_q;

endmodule

>>> sv/bcsh_checker.sv
// ----------------------------------------------------------------------------
// bcsh_checker
// Port-level checks of the bit crusher, bound to the top level.
// ----------------------------------------------------------------------------
module bcsh_checker import bcsh_pkg::*; #(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic signed [SAMPLE_WIDTH-1:0] left_out,
	input logic signed [SAMPLE_WIDTH-1:0] right_out
);

	// items inside the block, at most one per stage
	logic [1:0] inflight_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	// reset empties the pipeline and opens the input
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid && in_ready)
		else $error("block not idle in reset");

	// input only blocks behind a stalled result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without an output stall");

	// a stalled result keeps its samples
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
		else $error("stalled result changed");

	// no more than two items held, and no result without an item
	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 2'd2 && (!out_valid || inflight_q != 2'd0))
		else $error("item count out of range");

endmodule

bind bitcrusher_sample_hold bcsh_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_bcsh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.left_out (left_out),
	.right_out(right_out)
);

>>> dv/bitcrusher_sample_hold_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitcrusher_sample_hold_tb
// Self-checking bench for the stereo bit crusher with sample and hold. A
// scoreboard object tracks the phase accumulator, the rounding and the held
// samples, and every output item is compared against it. Directed items hit
// the rounding corners, then random bursts run across a range of depth and
// increment settings while the output side stalls and holds off.
// ----------------------------------------------------------------------------
module bitcrusher_sample_hold_tb;
	import bcsh_pkg::*;

	localparam int SW          = DEF_SAMPLE_WIDTH;
	localparam int PF          = DEF_PHASE_FRAC_BITS;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SHOWN_ERRS  = 10;

	// phase of 1.0 at the accumulator width
	localparam logic [PF:0] PH_ONE = (PF+1)'(1) << PF;

	// one stereo frame, used for inputs and for held outputs alike
	typedef struct packed {
		logic signed [SW-1:0] left;
		logic signed [SW-1:0] right;
	} frame_t;

	// tracks phase and held samples, queues the frames the block owes us
	class held_frame_board;
		logic [BIT_DEPTH_W-1:0] depth;
		logic [PF:0]            phase_inc;
		logic [PF:0]            phase_acc;
		logic [SW-1:0]          held_l;
		logic [SW-1:0]          held_r;
		frame_t                 frames_due[$];
		int                     errors;
		int                     seen;

		function new();
			depth     = PASS_DEPTH;
			phase_inc = PH_ONE;
			phase_acc = '0;
			held_l    = '0;
			held_r    = '0;
			errors    = 0;
			seen      = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [PF:0] value);
			if (idx == REG_BIT_DEPTH)
				depth = value[BIT_DEPTH_W-1:0];
			else
				phase_inc = value;
		endfunction

		// round half away from zero to a multiple of 2^(SW-1-depth)
		function logic [SW-1:0] quantize(logic [SW-1:0] s);
			logic [SW:0] mag;
			logic [SW:0] half;
			logic [SW:0] neg_mag;
			int          k;
			if (depth >= PASS_DEPTH)
				return s;
			k    = SW - 1 - int'(depth);
			mag  = s[SW-1] ? ((SW+1)'(1) << SW) - {1'b0, s} : {1'b0, s};
			half = (k > 0) ? ((SW+1)'(1) << (k - 1)) : '0;
			mag  = ((mag + half) >> k) << k;
			if (!s[SW-1]) begin
				// positive side clips at the largest code
				if (mag >= ((SW+1)'(1) << (SW - 1)))
					return {1'b0, {(SW-1){1'b1}}};
				return mag[SW-1:0];
			end
			neg_mag = '0 - mag;
			return neg_mag[SW-1:0];
		endfunction

		function void take_frame(frame_t f);
			logic [PF:0] step;
			frame_t      held;
			step = (phase_inc > PH_ONE) ? PH_ONE : phase_inc;
			phase_acc = phase_acc + step;
			if (phase_acc >= PH_ONE) begin
				phase_acc = phase_acc - PH_ONE;
				held_l    = quantize(f.left);
				held_r    = quantize(f.right);
			end
			held.left  = held_l;
			held.right = held_r;
			frames_due.push_back(held);
		endfunction

		function void match_frame(frame_t got);
			frame_t want;
			seen++;
			if (frames_due.size() == 0) begin
				errors++;
				if (errors <= SHOWN_ERRS)
					$display("output item %0d arrived with nothing pending: left %0d right %0d",
						seen, got.left, got.right);
				return;
			end
			want = frames_due.pop_front();
			if (got.left !== want.left || got.right !== want.right) begin
				errors++;
				if (errors <= SHOWN_ERRS)
					$display("output item %0d: expected left %0d right %0d, got left %0d right %0d",
						seen, want.left, want.right, got.left, got.right);
			end
		endfunction

		function int pending();
			return frames_due.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [SW-1:0]    left_in;
	logic signed [SW-1:0]    right_in;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [SW-1:0]    left_out;
	logic signed [SW-1:0]    right_out;
	logic                    cfg_we;
	logic [CFG_ADDR_W-1:0]   cfg_addr;
	logic [PF:0]             cfg_wdata;

	held_frame_board         board;
	frame_t                  script[$];      // directed frames, sent before random ones
	logic [BIT_DEPTH_W-1:0]  crush_depth;    // steers the boundary values in the stimulus
	int                      ready_mode;     // 0 always ready, 1 random stalls, 2 pattern
	logic [7:0]              ready_pattern;
	int                      hold_req;       // long hold-off asked of the receiver
	int                      cycle_count;

	bitcrusher_sample_hold DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.left_in   (left_in),
		.right_in  (right_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.left_out  (left_out),
		.right_out (right_out),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop in case the block wedges
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("bitcrusher_sample_hold_tb: done, errors");
			$finish;
		end
	end

	// output monitor: everything is sampled at the rising edge, before the
	// block's own registers move
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.match_frame(frame_t'{left_out, right_out});
	end

	// receiver: changes out_ready on the falling edge, either following the
	// current stall mode or sitting out a long hold-off it counts itself
	initial begin : receiver
		int tick;
		int hold_left;
		tick      = 0;
		hold_left = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			tick++;
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (ready_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 2) != 0);
					default: out_ready <= ready_pattern[tick[2:0]];
				endcase
			end
		end
	end

	// random sample, biased toward extremes and toward the rounding midpoints
	// of the current depth so the half-away-from-zero and clip paths get hit
	function automatic logic [SW-1:0] pick_sample();
		int unsigned   sel;
		int            k;
		logic [SW-1:0] base;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return SW'($urandom);
		if (sel < 70) begin
			case ($urandom_range(0, 5))
				0: return 24'h7FFFFF;
				1: return 24'h800000;
				2: return 24'h000000;
				3: return 24'hFFFFFF;
				4: return 24'h000001;
				default: return 24'h800001;
			endcase
		end
		k = (crush_depth >= PASS_DEPTH) ? $urandom_range(1, SW - 1) : SW - 1 - int'(crush_depth);
		if (k == 0)
			return SW'($urandom);
		base = SW'($urandom);
		base = (base >> k) << k;
		return base + (SW'(1) << (k - 1)) + SW'($urandom_range(0, 2)) - SW'(1);
	endfunction

	// both registers in back-to-back writes; starts and ends on a falling edge
	task automatic set_config(logic [BIT_DEPTH_W-1:0] depth, logic [PF:0] inc);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_BIT_DEPTH;
		cfg_wdata <= (PF+1)'(depth);
		@(posedge clk);
		board.write_reg(REG_BIT_DEPTH, (PF+1)'(depth));
		crush_depth = depth;
		@(negedge clk);
		cfg_addr  <= REG_PHASE_INC;
		cfg_wdata <= inc;
		@(posedge clk);
		board.write_reg(REG_PHASE_INC, inc);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// sender: offers n items, taking them from the script first; in bursty
	// mode it drops valid for a random gap between bursts
	task automatic send_frames(int n, bit bursty);
		int     burst_left;
		int     gap;
		frame_t f;
		burst_left = bursty ? $urandom_range(1, 20) : n;
		for (int i = 0; i < n; i++) begin
			if (script.size() != 0)
				f = script.pop_front();
			else
				f = frame_t'{pick_sample(), pick_sample()};
			in_valid <= 1'b1;
			left_in  <= f.left;
			right_in <= f.right;
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			board.take_frame(f);
			@(negedge clk);
			burst_left--;
			if (burst_left == 0 && i < n - 1) begin
				burst_left = $urandom_range(1, 20);
				gap        = $urandom_range(1, 8);
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	// wait for every owed item, then let the two pipeline stages settle
	task automatic wait_drained();
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin : stimulus
		bit                     bursty;
		logic [BIT_DEPTH_W-1:0] depth;
		logic [PF:0]            inc;
		board         = new();
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		left_in       = '0;
		right_in      = '0;
		cfg_we        = 1'b0;
		cfg_addr      = REG_BIT_DEPTH;
		cfg_wdata     = '0;
		crush_depth   = PASS_DEPTH;
		ready_mode    = 1;
		ready_pattern = 8'hFF;
		hold_req      = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset settings: full depth, capture every item
		script.push_back(frame_t'{24'h7FFFFF, 24'h800000});
		script.push_back(frame_t'{24'h800000, 24'h7FFFFF});
		script.push_back(frame_t'{24'h000000, 24'hFFFFFF});
		send_frames(script.size(), 0);
		wait_drained();

		// one bit: positive full scale clips, negative full scale is exact
		set_config(5'd1, 17'h10000);
		script.push_back(frame_t'{24'h7FFFFF, 24'h800000});
		script.push_back(frame_t'{24'h3FFFFF, 24'hC00001});
		script.push_back(frame_t'{24'h400000, 24'hBFFFFF});
		send_frames(script.size(), 0);
		wait_drained();

		// zero depth acts as a step of full scale: midpoints go to +clip or -1.0
		set_config(5'd0, 17'h10000);
		script.push_back(frame_t'{24'h400000, 24'hC00000});
		script.push_back(frame_t'{24'h3FFFFF, 24'hC00001});
		script.push_back(frame_t'{24'h7FFFFF, 24'h800000});
		send_frames(script.size(), 0);
		wait_drained();

		// exact midpoints on both sides, and one below each
		set_config(5'd8, 17'h10000);
		script.push_back(frame_t'{24'h00C000, 24'hFF4000});
		script.push_back(frame_t'{24'h00BFFF, 24'hFF4001});
		send_frames(script.size(), 0);
		wait_drained();

		// finest rounding depth, rounding up into the clip
		set_config(5'd15, 17'h10000);
		script.push_back(frame_t'{24'h000080, 24'hFFFF80});
		script.push_back(frame_t'{24'h7FFF80, 24'h000001});
		send_frames(script.size(), 0);
		wait_drained();

		// depth above 16 passes through, increment above 1.0 is clamped
		set_config(5'd31, 17'h1FFFF);
		script.push_back(frame_t'{24'h123456, 24'hFEDCBA});
		script.push_back(frame_t'{24'h800000, 24'h7FFFFF});
		send_frames(script.size(), 0);
		wait_drained();

		// zero increment: nothing new is captured
		set_config(5'd31, 17'h00000);
		script.push_back(frame_t'{24'h000001, 24'h000002});
		script.push_back(frame_t'{24'h555555, 24'hAAAAAA});
		script.push_back(frame_t'{24'hAAAAAA, 24'h555555});
		send_frames(script.size(), 0);
		wait_drained();

		// half rate: every other item captures
		set_config(5'd4, 17'h08000);
		script.push_back(frame_t'{24'h0FFFFF, 24'hF00000});
		script.push_back(frame_t'{24'h654321, 24'h9ABCDE});
		script.push_back(frame_t'{24'h081234, 24'hF7EDCC});
		script.push_back(frame_t'{24'h7FFFFF, 24'h800000});
		send_frames(script.size(), 0);
		wait_drained();

		// random phases; settings change only between phases with the block idle
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin depth = 5'd16; inc = 17'h10000; end
				1: begin depth = 5'd1;  inc = 17'h00001; end
				2: begin depth = 5'd0;  inc = 17'h1FFFF; end
				3: begin
					depth = 5'($urandom_range(2, 15));
					inc   = 17'($urandom_range(16384, 65535));
				end
				4: begin depth = 5'd31; inc = 17'h00000; end
				5: begin
					depth = 5'($urandom_range(17, 30));
					inc   = 17'($urandom_range(65537, 131071));
				end
				default: begin
					depth = 5'($urandom_range(0, 15));
					inc   = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(1, 4096))
						: 17'($urandom_range(8192, 65536));
				end
			endcase
			set_config(depth, inc);
			ready_mode    = ph % 3;
			ready_pattern = 8'($urandom) | 8'h01;
			bursty        = (ph % 4 != 1);
			// long output hold-off while the sender keeps pushing, so the
			// pipeline fills and in_ready has to drop
			if (ph == 3 || ph == 6) begin
				hold_req = $urandom_range(40, 80);
				bursty   = 1'b0;
			end
			send_frames(85, bursty);
			wait_drained();
		end

		board.errors += board.pending();
		if (board.errors == 0)
			$display("bitcrusher_sample_hold_tb: done, clean");
		else
			$display("bitcrusher_sample_hold_tb: done, errors");
		$finish;
	end

endmodule

>>> bitcrusher_sample_hold.f
sv/bcsh_pkg.sv
sv/bcsh_phase.sv
sv/bcsh_quant.sv
sv/bitcrusher_sample_hold.sv
sv/bcsh_checker.sv
dv/bitcrusher_sample_hold_tb.sv
